>>> src/tlptm_pkg.sv
// Shared types and codes for the two-level page table manager.
// No dependencies; used by the controller, the datapath and the top level.
package tlptm_pkg;

  // Operation codes carried in the func field
  localparam logic [2:0] FN_MAP       = 3'd0;
  localparam logic [2:0] FN_UNMAP     = 3'd1;
  localparam logic [2:0] FN_TRANSLATE = 3'd2;
  localparam logic [2:0] FN_IS_MAPPED = 3'd3;
  localparam logic [2:0] FN_ACCESS    = 3'd4;
  localparam logic [2:0] FN_RESERVE   = 3'd5;

  // Status codes reported with each result
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd1;
  localparam logic [2:0] ST_NO_FRAME    = 3'd2;
  localparam logic [2:0] ST_SEALED      = 3'd3;
  localparam logic [2:0] ST_DENIED      = 3'd4;

  // Configuration register indexes
  localparam logic CFG_KERNEL_FIRST_DIR = 1'b0;
  localparam logic CFG_SEALED           = 1'b1;

  // Entry flag bits
  localparam int unsigned PF_PRESENT_BIT  = 0;
  localparam int unsigned PF_WRITABLE_BIT = 1;
  localparam int unsigned PF_USER_BIT     = 2;

  localparam logic [9:0] KERNEL_FIRST_DIR_RST = 10'd768;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] virtual_addr;
    logic [31:0] physical_addr;
    logic [11:0] map_flags;
    logic        needs_write;
    logic [19:0] spare_frame;
    logic        spare_valid;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [31:0] phys_result;
    logic        spare_used;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_READ,
    S_EVAL,
    S_TCLEAR,
    S_PTWRITE
  } state_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_NOT_PRESENT,
    RES_NO_FRAME,
    RES_SEALED,
    RES_DENIED,
    RES_XLATE
  } res_t;

  typedef struct packed {
    logic item_load;
    logic cnt_clear;
    logic cnt_inc;
    logic dir_clr_wr;
    logic dir_upd_wr;
    logic dir_new_wr;
    logic pt_clr_wr;
    logic pt_map_wr;
    logic pt_zero_wr;
    logic finish;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       dir_present;
    logic       pt_present;
    logic       kernel_block;
    logic       spare_ok;
    logic       access_ok;
    logic       cnt_last_dir;
    logic       cnt_last_tab;
  } sts_t;

endpackage

>>> src/tlptm_ctrl.sv
// Controller state machine of the page table manager.
// Depends on tlptm_pkg; drives the datapath through cmd_t, watches sts_t.
module tlptm_ctrl import tlptm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.cnt_last_dir) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_INDEX;
      end
      S_INDEX: state_nxt = S_READ;
      S_READ:  state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (sts.func == FN_MAP || sts.func == FN_RESERVE) begin
          if (sts.dir_present) begin
            if (sts.func == FN_MAP) state_nxt = S_PTWRITE;
          end else if (!sts.kernel_block && sts.spare_ok) begin
            state_nxt = S_TCLEAR;
          end
        end
      end
      S_TCLEAR: begin
        if (sts.cnt_last_tab) begin
          state_nxt = (sts.func == FN_MAP) ? S_PTWRITE : S_IDLE;
        end
      end
      S_PTWRITE: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.res = RES_OK;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.dir_clr_wr = 1'b1;
        cmd.cnt_inc    = 1'b1;
      end
      S_IDLE: begin
        cmd.item_load = start;
      end
      S_EVAL: begin
        case (sts.func)
          FN_MAP, FN_RESERVE: begin
            if (sts.dir_present) begin
              cmd.dir_upd_wr = 1'b1;
              cmd.finish     = (sts.func == FN_RESERVE);
            end else if (sts.kernel_block) begin
              cmd.finish = 1'b1;
              cmd.res    = RES_SEALED;
            end else if (!sts.spare_ok) begin
              cmd.finish = 1'b1;
              cmd.res    = RES_NO_FRAME;
            end else begin
              cmd.dir_new_wr = 1'b1;
              cmd.cnt_clear  = 1'b1;
            end
          end
          FN_UNMAP: begin
            cmd.finish = 1'b1;
            if (sts.dir_present && sts.pt_present) begin
              cmd.pt_zero_wr = 1'b1;
            end else begin
              cmd.res = RES_NOT_PRESENT;
            end
          end
          FN_TRANSLATE: begin
            cmd.finish = 1'b1;
            cmd.res = (sts.dir_present && sts.pt_present) ? RES_XLATE : RES_NOT_PRESENT;
          end
          FN_IS_MAPPED: begin
            cmd.finish = 1'b1;
            cmd.res = (sts.dir_present && sts.pt_present) ? RES_OK : RES_NOT_PRESENT;
          end
          FN_ACCESS: begin
            cmd.finish = 1'b1;
            cmd.res = sts.access_ok ? RES_OK : RES_DENIED;
          end
          default: begin
            cmd.finish = 1'b1;
            cmd.res    = RES_NOT_PRESENT;
          end
        endcase
      end
      S_TCLEAR: begin
        cmd.pt_clr_wr = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.finish    = sts.cnt_last_tab && (sts.func != FN_MAP);
      end
      S_PTWRITE: begin
        cmd.pt_map_wr = 1'b1;
        cmd.finish    = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // No result may come out of the reset clearing pass
  a_no_finish_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !cmd.finish)
    else $error("result issued during directory clear");

  // A new directory entry is never made for a refused or frameless request
  a_new_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dir_new_wr |-> (!sts.kernel_block && sts.spare_ok && !sts.dir_present))
    else $error("illegal directory entry creation");

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // One finish per item: finishing returns to idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == S_IDLE))
    else $error("finish did not return to idle");
`endif

endmodule

>>> src/tlptm_dp.sv
// Datapath of the page table manager: item register, index reduction,
// directory and page table memories, config registers, result register.
// Depends on tlptm_pkg; commanded by tlptm_ctrl.
module tlptm_dp import tlptm_pkg::*; #(
  parameter int unsigned DIR_ENTRIES   = 1024,
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      cfg_valid,
  input  logic      cfg_index,
  input  logic [9:0] cfg_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned DW = $clog2(DIR_ENTRIES);
  localparam int unsigned TW = $clog2(TABLE_ENTRIES);
  localparam int unsigned MAXN = (DIR_ENTRIES > TABLE_ENTRIES) ? DIR_ENTRIES : TABLE_ENTRIES;
  localparam int unsigned CW = $clog2(MAXN);
  localparam logic [19:0] DREC = 20'((1 << 20) / DIR_ENTRIES);
  localparam logic [19:0] TREC = 20'((1 << 20) / TABLE_ENTRIES);
  localparam logic [10:0] DCONST = 11'(DIR_ENTRIES);
  localparam logic [10:0] TCONST = 11'(TABLE_ENTRIES);

  in_item_t        item_r;
  logic [9:0]      dq_r, tq_r;
  logic [DW-1:0]   dir_idx_r;
  logic [TW-1:0]   tab_idx_r;
  logic [CW-1:0]   cnt_r;
  logic [9:0]      kfd_r;
  logic            sealed_r;
  logic            used_r;
  logic [31:0]     dir_q_r, pt_q_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic [29:0]     dprod, tprod;
  logic [10:0]     drem, trem;
  logic [2:0]      req;
  logic            user_bit;
  logic [DW-1:0]   dir_waddr;
  logic [31:0]     dir_wdata;
  logic            dir_we;
  logic [TW-1:0]   pt_waddr;
  logic [31:0]     pt_wdata;
  logic            pt_we;

  logic [31:0] dir_mem [DIR_ENTRIES];
  logic [31:0] pt_mem  [DIR_ENTRIES][TABLE_ENTRIES];

  // Reciprocal estimate of the quotient for index reduction
  assign dprod = 30'(in_item.virtual_addr[31:22]) * 30'(DREC);
  assign tprod = 30'(in_item.virtual_addr[21:12]) * 30'(TREC);

  // Remainder with one correction step
  always_comb begin
    drem = {1'b0, item_r.virtual_addr[31:22]} - 11'(dq_r * DCONST);
    if (drem >= DCONST) drem = drem - DCONST;
    trem = {1'b0, item_r.virtual_addr[21:12]} - 11'(tq_r * TCONST);
    if (trem >= TCONST) trem = trem - TCONST;
  end

  // Hold item, quotient estimates and reduced indexes
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r <= in_item;
      dq_r   <= dprod[29:20];
      tq_r   <= tprod[29:20];
    end
    dir_idx_r <= drem[DW-1:0];
    tab_idx_r <= trem[TW-1:0];
  end

  // Sweep counter for clearing passes
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clear) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kfd_r    <= KERNEL_FIRST_DIR_RST;
      sealed_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KERNEL_FIRST_DIR: kfd_r    <= cfg_data;
        CFG_SEALED:           sealed_r <= cfg_data[0];
        default:              ;
      endcase
    end
  end

  // Directory write selection
  assign user_bit = (item_r.func == FN_MAP) ? item_r.map_flags[PF_USER_BIT] : 1'b0;
  always_comb begin
    dir_we    = cmd.dir_clr_wr | cmd.dir_upd_wr | cmd.dir_new_wr;
    dir_waddr = cmd.dir_clr_wr ? cnt_r[DW-1:0] : dir_idx_r;
    if (cmd.dir_clr_wr) begin
      dir_wdata = '0;
    end else if (cmd.dir_new_wr) begin
      dir_wdata = {item_r.spare_frame, 9'd0, user_bit, 2'b11};
    end else begin
      dir_wdata = dir_q_r | {29'd0, user_bit, 2'b00};
    end
  end

  // Page table write selection
  always_comb begin
    pt_we    = cmd.pt_clr_wr | cmd.pt_map_wr | cmd.pt_zero_wr;
    pt_waddr = cmd.pt_clr_wr ? cnt_r[TW-1:0] : tab_idx_r;
    if (cmd.pt_map_wr) begin
      pt_wdata = {item_r.physical_addr[31:12], item_r.map_flags | 12'h001};
    end else begin
      pt_wdata = '0;
    end
  end

  // Directory memory
  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_q_r <= dir_mem[dir_idx_r];
  end

  // Page table memory
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[dir_idx_r][pt_waddr] <= pt_wdata;
    pt_q_r <= pt_mem[dir_idx_r][tab_idx_r];
  end

  // Status toward the controller
  assign req = {1'b1, item_r.needs_write, 1'b1};
  always_comb begin
    sts.func         = item_r.func;
    sts.dir_present  = dir_q_r[PF_PRESENT_BIT];
    sts.pt_present   = pt_q_r[PF_PRESENT_BIT];
    sts.kernel_block = sealed_r && (10'(dir_idx_r) >= kfd_r);
    sts.spare_ok     = item_r.spare_valid;
    sts.access_ok    = ((dir_q_r[2:0] & req) == req) && ((pt_q_r[2:0] & req) == req);
    sts.cnt_last_dir = (cnt_r == CW'(DIR_ENTRIES - 1));
    sts.cnt_last_tab = (cnt_r == CW'(TABLE_ENTRIES - 1));
  end

  // Track spare frame use for the current item
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.item_load) begin
      used_r <= 1'b0;
    end else if (cmd.dir_new_wr) begin
      used_r <= 1'b1;
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_item_r.spare_used  <= used_r | cmd.dir_new_wr;
      out_item_r.phys_result <= '0;
      out_item_r.ok          <= 1'b0;
      case (cmd.res)
        RES_OK: begin
          out_item_r.ok     <= 1'b1;
          out_item_r.status <= ST_OK;
        end
        RES_XLATE: begin
          out_item_r.ok          <= 1'b1;
          out_item_r.status      <= ST_OK;
          out_item_r.phys_result <= {pt_q_r[31:12], item_r.virtual_addr[11:0]};
        end
        RES_NO_FRAME: out_item_r.status <= ST_NO_FRAME;
        RES_SEALED:   out_item_r.status <= ST_SEALED;
        RES_DENIED:   out_item_r.status <= ST_DENIED;
        default:      out_item_r.status <= ST_NOT_PRESENT;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  // The strobe comes in the cycle after a finish command
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.finish))
    else $error("result strobe without finish");

  // Reduced indexes stay inside the tables
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> ((11'(dir_idx_r) < DCONST) && (11'(tab_idx_r) < TCONST)))
    else $error("index out of range");

  // A translate result carries the offset of the virtual address
  a_xlate_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && cmd.res == RES_XLATE) |=>
      (out_item_r.phys_result[11:0] == item_r.virtual_addr[11:0]))
    else $error("translate offset mismatch");
`endif

endmodule

>>> src/two_level_page_table_manager.sv
// Two-level page table manager: a lookup passes the index, read and evaluate
// states before the result register; a map that hits an existing table adds a
// page table write, and a new table is first cleared entry by entry. A new item
// is taken only while idle; the directory and table read ports are registered.
// After reset a clearing pass over every directory entry runs with busy high;
// config writes are taken at any time. The receiver cannot stall results.
module two_level_page_table_manager import tlptm_pkg::*; #(
  parameter int unsigned DIR_ENTRIES   = 1024,
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  tlptm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tlptm_dp #(
    .DIR_ENTRIES   (DIR_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> test/page_table_checker.sv
// Checker for the two-level page table manager: tracks accepted items,
// predicts each result from its own copy of the tables and compares.
// Depends on tlptm_pkg for the item types, operation and status codes.
`timescale 1ns / 1ps

module page_table_checker import tlptm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [9:0] cfg_data,
  output int        fail_count,
  output int        pending,
  output int        checked
);

  localparam int unsigned DIRS = 1024;
  localparam int unsigned TABS = 1024;
  localparam logic [31:0] F_PRESENT  = 32'd1 << PF_PRESENT_BIT;
  localparam logic [31:0] F_WRITABLE = 32'd1 << PF_WRITABLE_BIT;
  localparam logic [31:0] F_USER     = 32'd1 << PF_USER_BIT;

  logic [31:0] dir_model [DIRS];
  logic [31:0] pte_model [int unsigned];
  logic [9:0]  kernel_slot;
  logic        seal_on;
  out_item_t   expected_results [$];

  // Entries of a freshly cleared table are simply absent and read as zero
  function automatic logic [31:0] pte_read(int unsigned slot);
    return pte_model.exists(slot) ? pte_model[slot] : 32'd0;
  endfunction

  // Make sure a table exists for directory slot d where sealing and the spare frame allow
  function automatic logic [2:0] grow_table(int unsigned d, logic [31:0] user,
                                            in_item_t it, output logic used);
    used = 1'b0;
    if (dir_model[d] & F_PRESENT) begin
      dir_model[d] |= user;
      return ST_OK;
    end
    if (seal_on && d >= kernel_slot) return ST_SEALED;
    if (!it.spare_valid) return ST_NO_FRAME;
    dir_model[d] = {it.spare_frame, 12'd0} | F_PRESENT | F_WRITABLE | user;
    for (int unsigned k = 0; k < TABS; k++) pte_model.delete(d * TABS + k);
    used = 1'b1;
    return ST_OK;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int unsigned d, slot;
    logic [31:0] e, req;
    logic used;
    r = '0;
    r.status = ST_NOT_PRESENT;
    d = it.virtual_addr[31:22] % DIRS;
    slot = d * TABS + (it.virtual_addr[21:12] % TABS);
    case (it.func)
      FN_MAP: begin
        r.status = grow_table(d, {20'd0, it.map_flags} & F_USER, it, used);
        r.spare_used = used;
        if (r.status == ST_OK) begin
          pte_model[slot] = {it.physical_addr[31:12], it.map_flags} | F_PRESENT;
          r.ok = 1'b1;
        end
      end
      FN_UNMAP: begin
        if ((dir_model[d] & F_PRESENT) && (pte_read(slot) & F_PRESENT)) begin
          pte_model[slot] = 32'd0;
          r.ok = 1'b1;
          r.status = ST_OK;
        end
      end
      FN_TRANSLATE, FN_IS_MAPPED: begin
        e = (dir_model[d] & F_PRESENT) ? pte_read(slot) : 32'd0;
        if (e & F_PRESENT) begin
          r.ok = 1'b1;
          r.status = ST_OK;
          if (it.func == FN_TRANSLATE) r.phys_result = {e[31:12], it.virtual_addr[11:0]};
        end
      end
      FN_ACCESS: begin
        req = F_PRESENT | F_USER | (it.needs_write ? F_WRITABLE : 32'd0);
        if ((dir_model[d] & req) == req && (pte_read(slot) & req) == req) begin
          r.ok = 1'b1;
          r.status = ST_OK;
        end else begin
          r.status = ST_DENIED;
        end
      end
      FN_RESERVE: begin
        r.status = grow_table(d, 32'd0, it, used);
        r.spare_used = used;
        r.ok = (r.status == ST_OK);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track config writes, accepted items and result strobes
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < DIRS; i++) dir_model[i] = '0;
      pte_model.delete();
      kernel_slot = KERNEL_FIRST_DIR_RST;
      seal_on = 1'b0;
      expected_results.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_KERNEL_FIRST_DIR) kernel_slot = cfg_data;
        else seal_on = cfg_data[0];
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: %p", out_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_item.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_item.ok);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
          if (out_item.phys_result !== want.phys_result) begin
            $error("phys_result: expected %h, got %h", want.phys_result,
                   out_item.phys_result);
            fail_count++;
          end
          if (out_item.spare_used !== want.spare_used) begin
            $error("spare_used: expected %0d, got %0d", want.spare_used,
                   out_item.spare_used);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_result(in_item));
    end
    pending = expected_results.size();
  end

endmodule

>>> test/testbench.sv
// Top of the page table manager testbench: clock, reset, config phases,
// directed and random items, and the verdict. Depends on tlptm_pkg, the
// block and page_table_checker.
`timescale 1ns / 1ps

module testbench import tlptm_pkg::*;;

  localparam longint CYCLE_LIMIT = 6000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_KERNEL_FIRST_DIR;
  logic [9:0] cfg_data = '0;
  int         fail_count, pending, checked;
  longint     cycles = 0;
  int         items_sent = 0;
  int         idle_pct = 0;
  int unsigned dir_pool [12];
  int unsigned tab_pool [16];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_level_page_table_manager dut (.*);

  page_table_checker checker_i (.*);

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Hold one item until the block takes it; start stays high afterward unless an idle gap is drawn
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result is in
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_op(logic [2:0] fn, logic [31:0] va,
                                       logic [31:0] pa, logic [11:0] fl,
                                       logic nw, logic sv);
    in_item_t it;
    it.func = fn;
    it.virtual_addr = va;
    it.physical_addr = pa;
    it.map_flags = fl;
    it.needs_write = nw;
    it.spare_frame = 20'($urandom);
    it.spare_valid = sv;
    return it;
  endfunction

  // Mostly addresses from a small pool so that mappings get hit again
  function automatic in_item_t random_op();
    in_item_t it;
    int unsigned w;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    w = $urandom_range(99);
    if (w < 30) it.func = FN_MAP;
    else if (w < 42) it.func = FN_UNMAP;
    else if (w < 60) it.func = FN_TRANSLATE;
    else if (w < 72) it.func = FN_IS_MAPPED;
    else if (w < 87) it.func = FN_ACCESS;
    else if (w < 95) it.func = FN_RESERVE;
    else it.func = 3'($urandom_range(6, 7));
    if ($urandom_range(99) >= 5) begin
      it.virtual_addr[31:22] = 10'(dir_pool[$urandom_range(11)]);
      it.virtual_addr[21:12] = 10'(tab_pool[$urandom_range(15)]);
    end
    it.spare_valid = ($urandom_range(99) < 90);
    return it;
  endfunction

  initial begin
    int unsigned kfd_set [5] = '{768, 0, 1023, 512, 768};
    logic seal_set [5] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    int pct_set [5] = '{0, 48, 0, 6, 48};
    dir_pool[0] = 0; dir_pool[1] = 1023; dir_pool[2] = 767; dir_pool[3] = 768;
    dir_pool[4] = 511; dir_pool[5] = 512;
    for (int i = 6; i < 12; i++) dir_pool[i] = $urandom_range(1023);
    tab_pool[0] = 0; tab_pool[1] = 1023;
    for (int i = 2; i < 16; i++) tab_pool[i] = $urandom_range(1023);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: each operation, field extremes and the error cases other than sealing
    send_item(make_op(FN_TRANSLATE, 32'h0000_0123, '0, '0, 1'b0, 1'b1));
    send_item(make_op(FN_MAP, 32'h0000_0000, 32'h0000_0000, 12'h004, 1'b0, 1'b0));
    send_item(make_op(FN_MAP, 32'h0000_0000, 32'h0000_0000, 12'h004, 1'b0, 1'b1));
    send_item(make_op(FN_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b1));
    send_item(make_op(FN_TRANSLATE, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_TRANSLATE, 32'h0000_0ABC, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_TRANSLATE, 32'h0000_1000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_IS_MAPPED, 32'hFFFF_F000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_ACCESS, 32'h0000_0000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_ACCESS, 32'h0000_0000, '0, '0, 1'b1, 1'b0));
    send_item(make_op(FN_ACCESS, 32'hFFFF_FFFF, '0, '0, 1'b1, 1'b0));
    send_item(make_op(FN_ACCESS, 32'h4000_0000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_RESERVE, 32'h8000_0000, '0, '0, 1'b0, 1'b1));
    send_item(make_op(FN_RESERVE, 32'h8000_0000, '0, '0, 1'b0, 1'b1));
    send_item(make_op(FN_RESERVE, 32'h8040_0000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_MAP, 32'h8000_5000, 32'h1234_5FFF, 12'h004, 1'b0, 1'b0));
    send_item(make_op(FN_ACCESS, 32'h8000_5000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_UNMAP, 32'h0000_0000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_UNMAP, 32'h0000_0000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(FN_UNMAP, 32'h4000_0000, '0, '0, 1'b0, 1'b0));
    send_item(make_op(3'd6, 32'hFFFF_FFFF, '1, '1, 1'b1, 1'b1));
    send_item(make_op(3'd7, 32'h0000_0000, '1, '1, 1'b1, 1'b1));

    // Random phases, each with a register setting and idle rate from the sets above
    for (int p = 0; p < 5; p++) begin
      drain();
      idle_pct = 0;
      write_reg(CFG_KERNEL_FIRST_DIR, 10'(kfd_set[p]));
      write_reg(CFG_SEALED, {9'd0, seal_set[p]});
      idle_pct = pct_set[p];
      for (int n = 0; n < 340; n++) begin
        send_item(random_op());
        // Let the block run dry now and then
        if ($urandom_range(199) == 0) drain();
      end
    end
    drain();
    repeat (40) @(posedge clk);

    $display("Sent %0d items over five register settings, including sealed", items_sent);
    $display("kernel slots at 0 and 1023; %0d results checked.", checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
